### hdl/mld_pkg.sv
package mld_pkg;

    localparam int FRAME_BITS  = 18;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [4:0] ADDR_END  = 5'd8;
    localparam logic [4:0] FUNC_END  = 5'd10;
    localparam logic [4:0] FRAME_END = 5'(FRAME_BITS);
    localparam logic [4:0] LAST_BIT  = 5'(FRAME_BITS - 1);
    localparam logic [4:0] INDEX_MAX = 5'd31;

    localparam logic [1:0] MODE_FALL    = 2'd0;
    localparam logic [1:0] MODE_RISE    = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    localparam logic [2:0] CFG_OWN_ADDRESS  = 3'd0;
    localparam logic [2:0] CFG_LIGHT_ALWAYS = 3'd1;
    localparam logic [2:0] CFG_ONE_HIGH_MIN = 3'd2;
    localparam logic [2:0] CFG_ONE_HIGH_MAX = 3'd3;
    localparam logic [2:0] CFG_PERIOD_MIN   = 3'd4;
    localparam logic [2:0] CFG_PERIOD_MAX   = 3'd5;

    localparam logic [7:0] ONE_HIGH_MIN_RST = 8'd180;
    localparam logic [7:0] ONE_HIGH_MAX_RST = 8'd200;
    localparam logic [7:0] PERIOD_MIN_RST   = 8'd200;
    localparam logic [7:0] PERIOD_MAX_RST   = 8'd230;

    localparam logic [3:0] SPEED_REVERSE = 4'd1;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] tick_count;
    } t_in_beat;

    typedef struct packed {
        logic       applied;
        logic       light_fwd;
        logic       light_rev;
        logic [7:0] drive_a;
        logic [7:0] drive_b;
        logic       direction;
        logic       direction_changed;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] own_address;
        logic [7:0] one_high_min;
        logic [7:0] one_high_max;
        logic [7:0] period_min;
        logic [7:0] period_max;
    } t_front_cfg;

    typedef struct packed {
        logic       apply;
        logic       func_nz;
        logic [3:0] speed;
    } t_cmd;

endpackage

### hdl/mld_front.sv
module mld_front import mld_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_front_cfg i_cfg,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_beat   i_in_beat,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd       o_q_cmd
);

    logic [4:0] r_bit_index, n_bit_index;
    logic [7:0] r_last_high, n_last_high;
    logic       r_timer, n_timer;
    logic [7:0] r_addr, n_addr;
    logic [7:0] r_func, n_func;
    logic [7:0] r_speed, n_speed;
    logic [7:0] r_prev_addr, n_prev_addr;
    logic [7:0] r_prev_func, n_prev_func;
    logic [7:0] r_prev_speed, n_prev_speed;

    logic       fire;
    logic       one_fall;
    logic       one_rise;
    logic       period_ok;
    logic [7:0] spd_fall;
    logic       frame_eq;
    logic [4:0] idx_rise;
    logic [7:0] base_addr, base_func, base_speed;
    t_cmd       cmd;

    assign fire      = i_in_valid && !i_q_full;
    assign one_fall  = (i_in_beat.tick_count > i_cfg.one_high_min) &&
                       (i_in_beat.tick_count < i_cfg.one_high_max);
    assign one_rise  = (r_last_high > i_cfg.one_high_min) &&
                       (r_last_high < i_cfg.one_high_max);
    assign period_ok = (i_in_beat.tick_count > i_cfg.period_min) &&
                       (i_in_beat.tick_count < i_cfg.period_max);
    assign spd_fall  = {one_fall, r_speed[7:1]};
    assign frame_eq  = (r_prev_addr == r_addr) && (r_prev_func == r_func) &&
                       (r_prev_speed == spd_fall);
    assign idx_rise  = r_timer ? r_bit_index : 5'd0;
    assign base_addr  = (idx_rise == 5'd0) ? 8'd0 : r_addr;
    assign base_func  = (idx_rise == 5'd0) ? 8'd0 : r_func;
    assign base_speed = (idx_rise == 5'd0) ? 8'd0 : r_speed;

    always_comb begin
        n_bit_index  = r_bit_index;
        n_last_high  = r_last_high;
        n_timer      = r_timer;
        n_addr       = r_addr;
        n_func       = r_func;
        n_speed      = r_speed;
        n_prev_addr  = r_prev_addr;
        n_prev_func  = r_prev_func;
        n_prev_speed = r_prev_speed;
        cmd.apply    = 1'b0;
        cmd.func_nz  = (r_func != 8'd0);
        cmd.speed    = {spd_fall[6], spd_fall[4], spd_fall[2], spd_fall[0]};
        if (fire) begin
            unique case (i_in_beat.mode)
                MODE_FALL: begin
                    n_last_high = i_in_beat.tick_count;
                    if (r_bit_index == LAST_BIT) begin
                        n_bit_index = 5'd0;
                        if (frame_eq) begin
                            n_addr       = 8'd0;
                            n_func       = 8'd0;
                            n_speed      = 8'd0;
                            n_prev_addr  = 8'd0;
                            n_prev_func  = 8'd0;
                            n_prev_speed = 8'd0;
                            cmd.apply    = (r_addr != 8'd0) &&
                                           (r_addr == i_cfg.own_address);
                        end else begin
                            n_speed      = spd_fall;
                            n_prev_addr  = r_addr;
                            n_prev_func  = r_func;
                            n_prev_speed = spd_fall;
                        end
                    end
                end
                MODE_RISE: begin
                    n_timer = 1'b1;
                    if (period_ok) begin
                        n_addr  = base_addr;
                        n_func  = base_func;
                        n_speed = base_speed;
                        if (idx_rise < ADDR_END) begin
                            n_addr = {one_rise, base_addr[7:1]};
                        end else if (idx_rise < FUNC_END) begin
                            n_func = {one_rise, base_func[7:1]};
                        end else if (idx_rise < FRAME_END) begin
                            n_speed = {one_rise, base_speed[7:1]};
                        end
                        n_bit_index = (idx_rise == INDEX_MAX) ? idx_rise
                                                              : idx_rise + 5'd1;
                    end else begin
                        n_bit_index = 5'd0;
                    end
                end
                MODE_TIMEOUT: begin
                    n_timer = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_index  <= 5'd0;
            r_last_high  <= 8'd0;
            r_timer      <= 1'b0;
            r_addr       <= 8'd0;
            r_func       <= 8'd0;
            r_speed      <= 8'd0;
            r_prev_addr  <= 8'd0;
            r_prev_func  <= 8'd0;
            r_prev_speed <= 8'd0;
        end else begin
            r_bit_index  <= n_bit_index;
            r_last_high  <= n_last_high;
            r_timer      <= n_timer;
            r_addr       <= n_addr;
            r_func       <= n_func;
            r_speed      <= n_speed;
            r_prev_addr  <= n_prev_addr;
            r_prev_func  <= n_prev_func;
            r_prev_speed <= n_prev_speed;
        end
    end

    assign o_in_stall = i_q_full;
    assign o_q_push   = fire;
    assign o_q_cmd    = cmd;

endmodule

### hdl/mld_queue.sv
module mld_queue import mld_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_pop_cmd,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_pop_cmd = r_mem[r_rd_ptr];
    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);

endmodule

### hdl/mld_back.sv
module mld_back import mld_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_light_always,
    input  logic      i_q_empty,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    logic       r_dir, n_dir;
    logic       r_toggle_block, n_toggle_block;
    logic       r_light_fwd, n_light_fwd;
    logic       r_light_rev, n_light_rev;
    logic [7:0] r_drive_a, n_drive_a;
    logic [7:0] r_drive_b, n_drive_b;
    logic       r_out_valid;
    t_out_beat  r_out_beat;

    logic       pop;
    logic       do_apply;
    logic       rev_cmd;
    logic       toggled;
    logic [7:0] duty;
    logic       lights_on;
    t_out_beat  beat;

    assign pop       = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign do_apply  = pop && i_q_cmd.apply;
    assign rev_cmd   = (i_q_cmd.speed == SPEED_REVERSE);
    assign toggled   = do_apply && rev_cmd && !r_toggle_block;
    assign duty      = rev_cmd ? 8'd0 : {i_q_cmd.speed, 4'b0000};
    assign lights_on = i_q_cmd.func_nz || i_light_always;

    always_comb begin
        n_dir          = r_dir;
        n_toggle_block = r_toggle_block;
        n_light_fwd    = r_light_fwd;
        n_light_rev    = r_light_rev;
        n_drive_a      = r_drive_a;
        n_drive_b      = r_drive_b;
        if (do_apply) begin
            n_dir          = r_dir ^ toggled;
            n_toggle_block = rev_cmd;
            n_light_fwd    = lights_on && n_dir;
            n_light_rev    = lights_on && !n_dir;
            n_drive_a      = n_dir ? 8'd0 : duty;
            n_drive_b      = n_dir ? duty : 8'd0;
        end
        beat.applied           = do_apply;
        beat.light_fwd         = n_light_fwd;
        beat.light_rev         = n_light_rev;
        beat.drive_a           = n_drive_a;
        beat.drive_b           = n_drive_b;
        beat.direction         = n_dir;
        beat.direction_changed = toggled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir          <= 1'b0;
            r_toggle_block <= 1'b0;
            r_light_fwd    <= 1'b0;
            r_light_rev    <= 1'b0;
            r_drive_a      <= 8'd0;
            r_drive_b      <= 8'd0;
            r_out_valid    <= 1'b0;
        end else begin
            r_dir          <= n_dir;
            r_toggle_block <= n_toggle_block;
            r_light_fwd    <= n_light_fwd;
            r_light_rev    <= n_light_rev;
            r_drive_a      <= n_drive_a;
            r_drive_b      <= n_drive_b;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_beat <= beat;
        end
    end

    assign o_q_pop     = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

### hdl/motorola_loco_frame_decoder.sv
// path: an input beat's command is written into the queue, then popped into the registered output beat
// throughput: one beat per cycle while the queue is not full, each input beat yields exactly one result beat
// the front assembles frames, a two-entry command queue feeds the back end
// reset: synchronous active low, clears frame state, direction, output valid and queue
// config registers reset to address 0, one window bounds 180..200, period bounds 200..230 (both exclusive)
module motorola_loco_frame_decoder import mld_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_wr_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    t_front_cfg r_cfg;
    logic       r_light_always;

    logic q_push, q_full, q_pop, q_empty;
    t_cmd q_push_cmd, q_pop_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_address  <= 8'd0;
            r_cfg.one_high_min <= ONE_HIGH_MIN_RST;
            r_cfg.one_high_max <= ONE_HIGH_MAX_RST;
            r_cfg.period_min   <= PERIOD_MIN_RST;
            r_cfg.period_max   <= PERIOD_MAX_RST;
            r_light_always     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_OWN_ADDRESS:  r_cfg.own_address  <= i_cfg_wr_data;
                CFG_LIGHT_ALWAYS: r_light_always     <= i_cfg_wr_data[0];
                CFG_ONE_HIGH_MIN: r_cfg.one_high_min <= i_cfg_wr_data;
                CFG_ONE_HIGH_MAX: r_cfg.one_high_max <= i_cfg_wr_data;
                CFG_PERIOD_MIN:   r_cfg.period_min   <= i_cfg_wr_data;
                CFG_PERIOD_MAX:   r_cfg.period_max   <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    mld_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_push_cmd)
    );

    mld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_pop_cmd  (q_pop_cmd),
        .o_empty    (q_empty)
    );

    mld_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_light_always (r_light_always),
        .i_q_empty      (q_empty),
        .i_q_cmd        (q_pop_cmd),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_beat     (o_out_beat)
    );

endmodule
